>>> rtl/core/c80alu_pkg.sv
package c80alu_pkg;

    // operation codes
    localparam logic [4:0] OP_ADD = 5'd0;
    localparam logic [4:0] OP_ADC = 5'd1;
    localparam logic [4:0] OP_SUB = 5'd2;
    localparam logic [4:0] OP_SBB = 5'd3;
    localparam logic [4:0] OP_ANA = 5'd4;
    localparam logic [4:0] OP_XRA = 5'd5;
    localparam logic [4:0] OP_ORA = 5'd6;
    localparam logic [4:0] OP_CMP = 5'd7;
    localparam logic [4:0] OP_INR = 5'd8;
    localparam logic [4:0] OP_DCR = 5'd9;
    localparam logic [4:0] OP_RLC = 5'd10;
    localparam logic [4:0] OP_RRC = 5'd11;
    localparam logic [4:0] OP_RAL = 5'd12;
    localparam logic [4:0] OP_RAR = 5'd13;
    localparam logic [4:0] OP_DAA = 5'd14;
    localparam logic [4:0] OP_CMA = 5'd15;
    localparam logic [4:0] OP_STC = 5'd16;
    localparam logic [4:0] OP_CMC = 5'd17;

    // psw bit positions
    localparam int FL_S_BIT  = 7;
    localparam int FL_Z_BIT  = 6;
    localparam int FL_AC_BIT = 4;
    localparam int FL_P_BIT  = 2;
    localparam int FL_CY_BIT = 0;

    localparam logic [7:0] FL_KEEP = 8'hD5;
    localparam logic [7:0] FL_ONE  = 8'h02;

    typedef struct packed {
        logic [4:0] op;
        logic [7:0] acc;
        logic [7:0] opnd;
        logic [7:0] flags;
    } c80alu_req_t;

    typedef struct packed {
        logic [7:0] result;
        logic       write_back;
        logic [7:0] flags;
    } c80alu_rsp_t;

    // sign, zero and even parity of a result byte
    function automatic logic [7:0] szp(input logic [7:0] v);
        logic [7:0] f;
        begin
            f = 8'h00;
            f[FL_S_BIT] = v[7];
            f[FL_Z_BIT] = (v == 8'h00);
            f[FL_P_BIT] = ~(^v);
            return f;
        end
    endfunction

endpackage

>>> rtl/core/c80alu_core.sv
module c80alu_core
    import c80alu_pkg::*;
(
    input  c80alu_req_t req,
    output c80alu_rsp_t rsp
);

    logic [7:0] a;
    logic [7:0] b;
    logic       cy;
    logic [7:0] kept;
    logic [7:0] add_b;
    logic       add_cin;
    logic       add_borrow;
    logic [8:0] add_sum;
    logic [4:0] add_lo;
    logic [7:0] add_flags;
    logic [3:0] daa_lo;
    logic [3:0] daa_hi;
    logic       daa_lo_fix;
    logic       daa_hi_fix;
    logic [7:0] daa_corr;
    logic [4:0] daa_lo_sum;
    logic [7:0] r;
    logic [7:0] f;
    logic       wb;

    assign a    = req.acc;
    assign b    = req.opnd;
    assign cy   = req.flags[FL_CY_BIT];
    assign kept = req.flags & FL_KEEP;

    // shared adder, subtraction as a plus inverted b
    always_comb
    begin
        add_b      = b;
        add_cin    = 1'b0;
        add_borrow = 1'b0;
        case (req.op)
            OP_ADC:
            begin
                add_cin = cy;
            end
            OP_SUB, OP_CMP:
            begin
                add_b      = ~b;
                add_cin    = 1'b1;
                add_borrow = 1'b1;
            end
            OP_SBB:
            begin
                add_b      = ~b;
                add_cin    = ~cy;
                add_borrow = 1'b1;
            end
            default:
            begin
                add_b = b;
            end
        endcase
        add_sum = {1'b0, a} + {1'b0, add_b} + {8'h00, add_cin};
        add_lo  = {1'b0, a[3:0]} + {1'b0, add_b[3:0]} + {4'h0, add_cin};
        add_flags = szp(add_sum[7:0]);
        add_flags[FL_AC_BIT] = add_lo[4];
        add_flags[FL_CY_BIT] = add_sum[8] ^ add_borrow;
    end

    // decimal adjust
    always_comb
    begin
        daa_lo     = a[3:0];
        daa_hi     = a[7:4];
        daa_lo_fix = req.flags[FL_AC_BIT] || (daa_lo > 4'd9);
        daa_hi_fix = cy || (daa_hi > 4'd9) || ((daa_hi >= 4'd9) && (daa_lo > 4'd9));
        daa_corr   = {1'b0, daa_hi_fix, daa_hi_fix, 1'b0, 1'b0, daa_lo_fix, daa_lo_fix, 1'b0};
        daa_lo_sum = {1'b0, daa_lo} + {1'b0, daa_corr[3:0]};
    end

    always_comb
    begin
        r  = a;
        f  = kept;
        wb = 1'b1;
        case (req.op)
            OP_ADD, OP_ADC, OP_SUB, OP_SBB:
            begin
                r = add_sum[7:0];
                f = add_flags;
            end
            OP_CMP:
            begin
                r  = add_sum[7:0];
                f  = add_flags;
                wb = 1'b0;
            end
            OP_ANA:
            begin
                r = a & b;
                f = szp(a & b);
                f[FL_AC_BIT] = a[3] | b[3];
            end
            OP_XRA:
            begin
                r = a ^ b;
                f = szp(a ^ b);
            end
            OP_ORA:
            begin
                r = a | b;
                f = szp(a | b);
            end
            OP_INR:
            begin
                r = b + 8'd1;
                f = szp(b + 8'd1);
                f[FL_AC_BIT] = (r[3:0] == 4'h0);
                f[FL_CY_BIT] = cy;
            end
            OP_DCR:
            begin
                r = b - 8'd1;
                f = szp(b - 8'd1);
                f[FL_AC_BIT] = (r[3:0] != 4'hF);
                f[FL_CY_BIT] = cy;
            end
            OP_RLC:
            begin
                r = {a[6:0], a[7]};
                f[FL_CY_BIT] = a[7];
            end
            OP_RRC:
            begin
                r = {a[0], a[7:1]};
                f[FL_CY_BIT] = a[0];
            end
            OP_RAL:
            begin
                r = {a[6:0], cy};
                f[FL_CY_BIT] = a[7];
            end
            OP_RAR:
            begin
                r = {cy, a[7:1]};
                f[FL_CY_BIT] = a[0];
            end
            OP_DAA:
            begin
                r = a + daa_corr;
                f = szp(a + daa_corr);
                f[FL_AC_BIT] = daa_lo_sum[4];
                f[FL_CY_BIT] = cy | daa_hi_fix;
            end
            OP_CMA:
            begin
                r = ~a;
            end
            OP_STC:
            begin
                f[FL_CY_BIT] = 1'b1;
                wb = 1'b0;
            end
            OP_CMC:
            begin
                f[FL_CY_BIT] = ~cy;
                wb = 1'b0;
            end
            default:
            begin
                // unused codes behave as no operation
                wb = 1'b0;
            end
        endcase
        rsp.result     = r;
        rsp.write_back = wb;
        rsp.flags      = (f & FL_KEEP) | FL_ONE;
    end

endmodule

>>> rtl/core/cpu8080_alu_with_flags_top.sv
// channel | handshake           | payload
// input   | in_valid, in_ready   | req_type, acc_in, operand, flags_in
// output  | out_valid, out_ready | result, write_back, flags_out
//
// one item per cycle sustained while out_ready is high; an accepted item reaches the output
// through input register, one pass through the alu logic, result register
// rst_n clears both valid bits asynchronously; payload registers are not reset
// a stalled output holds its item while the input register still takes one more,
// so in_ready only drops when both stages are full and out_ready is low
module cpu8080_alu_with_flags_top
    import c80alu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [4:0] req_type,
    input  logic [7:0] acc_in,
    input  logic [7:0] operand,
    input  logic [7:0] flags_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] result,
    output logic       write_back,
    output logic [7:0] flags_out
);

    // input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    c80alu_req_t req_reg;
    c80alu_req_t req_next;

    // result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    c80alu_rsp_t rsp_reg;
    c80alu_rsp_t rsp_next;

    c80alu_rsp_t alu_rsp;
    logic        res_ready;

    // result stage can take an item when empty or being drained
    assign res_ready = ~out_valid_reg | out_ready;
    assign in_ready  = ~in_valid_reg | res_ready;

    c80alu_core u_core
    (
        .req (req_reg),
        .rsp (alu_rsp)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        req_next      = req_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
        if (in_valid && in_ready)
        begin
            req_next = '{op: req_type, acc: acc_in, opnd: operand, flags: flags_in};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        rsp_next       = rsp_reg;
        if (res_ready)
        begin
            out_valid_next = in_valid_reg;
        end
        if (in_valid_reg && res_ready)
        begin
            rsp_next = alu_rsp;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign out_valid  = out_valid_reg;
    assign result     = rsp_reg.result;
    assign write_back = rsp_reg.write_back;
    assign flags_out  = rsp_reg.flags;

endmodule
